/* src/retransmit_request_table_defines.svh */
// Assertion macros for the retransmit request table.
// Needs a clock named clk and a synchronous reset named rst in the including module.
`ifndef RETRANSMIT_REQUEST_TABLE_DEFINES_SVH
`define RETRANSMIT_REQUEST_TABLE_DEFINES_SVH

// Condition must hold at every clock edge outside reset
`define RRT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequence must hold on the clock after the antecedent
`define RRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/rrt_pkg.sv */
// Shared types and constants for the retransmit request table.
// No dependencies; imported by retransmit_request_table.
`default_nettype none

package rrt_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam logic [31:0] FIRST_IDENT    = 32'd10000;
  localparam logic [15:0] RESET_INTERVAL = 16'd5;

  // Opcodes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  // Result kinds
  localparam logic [2:0] KIND_INSERTED  = 3'd0;
  localparam logic [2:0] KIND_FULL      = 3'd1;
  localparam logic [2:0] KIND_REMOVED   = 3'd2;
  localparam logic [2:0] KIND_NOT_FOUND = 3'd3;
  localparam logic [2:0] KIND_SEND      = 3'd4;
  localparam logic [2:0] KIND_RESEND    = 3'd5;
  localparam logic [2:0] KIND_DONE      = 3'd6;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] request_handle;
    logic [31:0] lookup_id;
    logic [31:0] now_time;
  } req_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [31:0] out_id;
    logic [15:0] out_handle;
    logic        last;
  } rsp_t;

  // One table row as held in the entry memory
  typedef struct packed {
    logic [31:0] ident;
    logic [15:0] tag;
    logic        was_sent;
    logic [31:0] sent_time;
  } entry_t;

endpackage

`default_nettype wire

/* src/retransmit_request_table.sv */
// Retransmit request table: ordered table of outstanding requests with id issue,
// remove-by-id and timed resend scan. Depends on rrt_pkg and the assertion header.
//
// Usage:
//  - req channel (req_valid/req_ready/req): one operation per transaction. Insert
//    appends a handle and reports its new id (or table full); remove looks up an
//    id, closes the gap and returns the handle (or not found); tick walks the
//    table, giving a first send or resend per due entry and then a done item.
//  - rsp channel (rsp_valid/rsp_ready/rsp): result items, rsp.last on the final
//    item of each operation. Opcode 3 yields no items.
//  - cfg channel (cfg_valid/cfg_ready/cfg_interval): resend interval, always ready;
//    write only while the block is idle.
// Timing: one operation at a time. Insert goes straight to the FINISH state,
// which loads its result into the output register. Remove and tick read the
// entry memory one row per cycle (single registered read port), except while a
// tick scan is paused; the next request is taken the cycle after the last result
// is loaded into the output register.
// Reset: table empty, next id 10000, interval 5. The entry memory is not cleared.
// Stall: the output register holds until taken; a tick scan pauses on a due entry
// while the output register is occupied.
`default_nettype none

module retransmit_request_table (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         req_valid,
  output logic              req_ready,
  input  wire rrt_pkg::req_t req,
  output logic              rsp_valid,
  input  wire logic         rsp_ready,
  output rrt_pkg::rsp_t     rsp,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [15:0]  cfg_interval
);

  import rrt_pkg::*;

  `include "retransmit_request_table_defines.svh"

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]       state;
  req_t             cur;
  logic [CNT_W-1:0] count;
  logic [31:0]      next_ident;
  logic [15:0]      interval;
  logic [CNT_W-1:0] idx;
  logic             pv;
  logic [IDX_W-1:0] paddr;
  logic             found;
  logic [15:0]      found_tag;

  entry_t           mem [TABLE_ENTRIES];
  entry_t           rd_data;

  logic             slot_free;
  logic             more;
  logic [31:0]      age;
  logic             due;
  logic             is_tick;
  logic             is_remove;
  logic             emit;
  logic             adv;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             match;
  logic             full;
  logic             fin_go;
  logic             shift_we;
  logic             mem_we;
  logic [IDX_W-1:0] wr_addr;
  entry_t           mem_wd;
  logic             load;
  rsp_t             rsp_next;

  assign req_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // Scan datapath
  assign slot_free = !rsp_valid || rsp_ready;
  assign more      = idx < count;
  assign is_tick   = (cur.opcode == OP_TICK);
  assign is_remove = (cur.opcode == OP_REMOVE);
  assign age       = cur.now_time - rd_data.sent_time;
  assign due       = !rd_data.was_sent || (age > {16'd0, interval});
  assign emit      = (state == S_SCAN) && pv && is_tick && due;
  assign adv       = !pv || !emit || slot_free;
  assign rd_en     = (state == S_SCAN) && adv && more;
  assign rd_addr   = idx[IDX_W-1:0];
  assign match     = (state == S_SCAN) && pv && is_remove && !found
                     && (rd_data.ident == cur.lookup_id);
  assign shift_we  = (state == S_SCAN) && pv && is_remove && found;
  assign full      = (count == CNT_W'(TABLE_ENTRIES));
  assign fin_go    = (state == S_FINISH) && slot_free;

  // Memory write selection: insert append, remove shift-down, tick stamp
  always_comb begin
    mem_we  = 1'b0;
    wr_addr = paddr;
    mem_wd  = rd_data;
    if (fin_go && (cur.opcode == OP_INSERT) && !full) begin
      mem_we  = 1'b1;
      wr_addr = count[IDX_W-1:0];
      mem_wd  = '{ident: next_ident, tag: cur.request_handle,
                  was_sent: 1'b0, sent_time: 32'd0};
    end else if (shift_we) begin
      mem_we  = 1'b1;
      wr_addr = paddr - IDX_W'(1);
    end else if (emit && slot_free) begin
      mem_we            = 1'b1;
      mem_wd.was_sent   = 1'b1;
      mem_wd.sent_time  = cur.now_time;
    end
  end

  // Result item selection
  always_comb begin
    load     = (emit && slot_free) || fin_go;
    rsp_next = '{result_kind: KIND_DONE, out_id: 32'd0, out_handle: 16'd0, last: 1'b1};
    if (emit) begin
      rsp_next.result_kind = rd_data.was_sent ? KIND_RESEND : KIND_SEND;
      rsp_next.out_id      = rd_data.ident;
      rsp_next.out_handle  = rd_data.tag;
      rsp_next.last        = 1'b0;
    end else begin
      unique case (cur.opcode)
        OP_INSERT: begin
          rsp_next.result_kind = full ? KIND_FULL : KIND_INSERTED;
          rsp_next.out_id      = full ? 32'd0 : next_ident;
          rsp_next.out_handle  = cur.request_handle;
        end
        OP_REMOVE: begin
          rsp_next.result_kind = found ? KIND_REMOVED : KIND_NOT_FOUND;
          rsp_next.out_id      = cur.lookup_id;
          rsp_next.out_handle  = found ? found_tag : 16'd0;
        end
        default: begin
          rsp_next.result_kind = KIND_DONE;
        end
      endcase
    end
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= mem_wd;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      cur <= req;
    end
    if (rd_en) begin
      paddr <= rd_addr;
    end
    if (match) begin
      found_tag <= rd_data.tag;
    end
    if (load) begin
      rsp <= rsp_next;
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      next_ident <= FIRST_IDENT;
      interval   <= RESET_INTERVAL;
      idx        <= '0;
      pv         <= 1'b0;
      found      <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        interval <= cfg_interval;
      end

      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            idx   <= '0;
            pv    <= 1'b0;
            found <= 1'b0;
            if (req.opcode == OP_INSERT) begin
              state <= S_FINISH;
            end else if (req.opcode == OP_REMOVE || req.opcode == OP_TICK) begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (rd_en) begin
            idx <= idx + CNT_W'(1);
          end
          if (adv) begin
            pv <= rd_en;
          end
          if (match) begin
            found <= 1'b1;
          end
          if (!pv && !more) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (slot_free) begin
            state <= S_IDLE;
            if (cur.opcode == OP_INSERT && !full) begin
              count      <= count + CNT_W'(1);
              next_ident <= next_ident + 32'd1;
            end else if (cur.opcode == OP_REMOVE && found) begin
              count <= count - CNT_W'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  `RRT_ASSERT_ALWAYS(a_count_bound, count <= CNT_W'(TABLE_ENTRIES), "entry count above table size")
  `RRT_ASSERT_ALWAYS(a_no_rw_clash, !(mem_we && rd_en && wr_addr == rd_addr), "write hits row being read")
  `RRT_ASSERT_NEXT(a_remove_shrinks, fin_go && is_remove && found, count == $past(count) - CNT_W'(1), "remove did not shrink table")
  `RRT_ASSERT_NEXT(a_insert_id, fin_go && cur.opcode == OP_INSERT && !full, next_ident == $past(next_ident) + 32'd1, "id counter not advanced")
  `RRT_ASSERT_ALWAYS(a_hold_on_stall, !(rsp_valid && !rsp_ready && load), "result overwritten while stalled")

endmodule

`default_nettype wire

/* dv/retransmit_request_table_test.sv */
// Self-checking testbench for the retransmit request table: directed and random traffic.
// Needs rrt_pkg and retransmit_request_table; results are predicted from a local copy of
// the table and compared transaction by transaction on the response channel.
module retransmit_request_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rrt_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 40;
  localparam int LIMIT_NS = 1_500_000;
  localparam int REPORT_LIMIT = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_interval = '0;

  // Local copy of the table
  logic [31:0] row_ident [TABLE_ENTRIES];
  logic [15:0] row_tag [TABLE_ENTRIES];
  logic row_sent [TABLE_ENTRIES];
  logic [31:0] row_stamp [TABLE_ENTRIES];
  int row_count = 0;
  logic [31:0] issue_ident = FIRST_IDENT;
  logic [15:0] row_interval = RESET_INTERVAL;

  rsp_t due_results [$];
  int mismatch_count = 0;
  bit idling_on = 1'b1;
  int hold_off_cycles = 0;
  logic [31:0] tick_clock = '0;

  retransmit_request_table dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_interval(cfg_interval)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Run limit
  initial begin
    #LIMIT_NS;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic void queue_result(input logic [2:0] kind, input logic [31:0] id,
                                       input logic [15:0] handle, input logic fin);
    rsp_t r;
    r.result_kind = kind;
    r.out_id = id;
    r.out_handle = handle;
    r.last = fin;
    due_results.push_back(r);
  endfunction

  // Update the local table with one accepted operation and queue its results
  task automatic apply_table_op(input req_t op);
    int hit;
    logic [15:0] tag;
    hit = -1;
    case (op.opcode)
      OP_INSERT: begin
        if (row_count >= TABLE_ENTRIES) begin
          queue_result(KIND_FULL, '0, op.request_handle, 1'b1);
        end else begin
          row_ident[row_count] = issue_ident;
          row_tag[row_count] = op.request_handle;
          row_sent[row_count] = 1'b0;
          row_stamp[row_count] = '0;
          row_count++;
          queue_result(KIND_INSERTED, issue_ident, op.request_handle, 1'b1);
          issue_ident = issue_ident + 32'd1;
        end
      end
      OP_REMOVE: begin
        // oldest matching entry wins
        for (int i = 0; i < row_count; i++) begin
          if (hit < 0 && row_ident[i] == op.lookup_id) hit = i;
        end
        if (hit < 0) begin
          queue_result(KIND_NOT_FOUND, op.lookup_id, '0, 1'b1);
        end else begin
          tag = row_tag[hit];
          for (int j = hit; j + 1 < row_count; j++) begin
            row_ident[j] = row_ident[j + 1];
            row_tag[j] = row_tag[j + 1];
            row_sent[j] = row_sent[j + 1];
            row_stamp[j] = row_stamp[j + 1];
          end
          row_count--;
          queue_result(KIND_REMOVED, op.lookup_id, tag, 1'b1);
        end
      end
      OP_TICK: begin
        for (int i = 0; i < row_count; i++) begin
          if (!row_sent[i]) begin
            queue_result(KIND_SEND, row_ident[i], row_tag[i], 1'b0);
            row_sent[i] = 1'b1;
            row_stamp[i] = op.now_time;
          end else if ((op.now_time - row_stamp[i]) > {16'd0, row_interval}) begin
            // age taken modulo 2^32
            queue_result(KIND_RESEND, row_ident[i], row_tag[i], 1'b0);
            row_stamp[i] = op.now_time;
          end
        end
        queue_result(KIND_DONE, '0, '0, 1'b1);
      end
      default: ;
    endcase
  endtask

  function automatic req_t make_op(input logic [1:0] opcode, input logic [15:0] handle,
                                   input logic [31:0] id, input logic [31:0] now);
    req_t op;
    op.opcode = opcode;
    op.request_handle = handle;
    op.lookup_id = id;
    op.now_time = now;
    return op;
  endfunction

  // Offer one request transaction and wait for it to be taken
  task automatic send_op(input req_t op);
    int gap;
    gap = idling_on ? $urandom_range(0, 11) : 0;
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= op;
    do @(posedge clk); while (!req_ready);
    apply_table_op(op);
  endtask

  // Wait until every queued result has been taken and the block has settled
  task automatic wait_idle();
    req_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_interval(input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_interval <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    row_interval = value;
  endtask

  task automatic note_mismatch(input string what, input rsp_t want, input rsp_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("%0t: %s: expected kind %0d id %0d handle %h last %b, got kind %0d id %0d handle %h last %b",
               $realtime, what, want.result_kind, want.out_id, want.out_handle, want.last,
               got.result_kind, got.out_id, got.out_handle, got.last);
  endtask

  // Response side: random stalls per transaction, plus a long hold-off on request
  initial begin : receiver
    int stall;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_off_cycles > 0) begin
        rsp_ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end else begin
        stall = idling_on ? $urandom_range(0, 11) : 0;
        if (stall != 0) begin
          rsp_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        rsp_ready <= 1'b1;
        do @(posedge clk); while (!rsp_valid && hold_off_cycles == 0);
      end
    end
  end

  // Compare each response transaction with the oldest queued result
  always @(posedge clk) begin : check_results
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (due_results.size() == 0) begin
        note_mismatch("result with nothing pending", '0, rsp);
      end else begin
        want = due_results.pop_front();
        if (rsp.result_kind !== want.result_kind || rsp.out_id !== want.out_id ||
            rsp.out_handle !== want.out_handle || rsp.last !== want.last)
          note_mismatch("result mismatch", want, rsp);
      end
    end
  end

  // Empty table: tick gives only done, remove misses, opcode 3 is silent
  task automatic test_empty_table();
    send_op(make_op(OP_TICK, 16'($urandom_range(0, 65535)), $urandom, 32'd0));
    send_op(make_op(OP_REMOVE, 16'($urandom_range(0, 65535)), 32'hFFFF_FFFF, $urandom));
    send_op(make_op(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
  endtask

  // Fill every row, then one insert too many
  task automatic test_fill_and_overflow();
    logic [15:0] handle;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      handle = (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
      send_op(make_op(OP_INSERT, handle, $urandom, $urandom));
    end
    send_op(make_op(OP_INSERT, 16'hA5A5, $urandom, $urandom));
  endtask

  // First sends, an age equal to the interval, then a resend across the time wrap
  task automatic test_scan_ages();
    send_op(make_op(OP_TICK, '0, '0, 32'hFFFF_FFF0));
    send_op(make_op(OP_TICK, '0, '0, 32'hFFFF_FFF5));
    send_op(make_op(OP_TICK, '0, '0, 32'h0000_0002));
    tick_clock = 32'h0000_0002;
  endtask

  // Remove at the head, the tail and the middle, then a stale id
  task automatic test_remove_order();
    send_op(make_op(OP_REMOVE, '0, FIRST_IDENT, '0));
    send_op(make_op(OP_REMOVE, '0, FIRST_IDENT + 32'd15, '0));
    send_op(make_op(OP_REMOVE, '0, FIRST_IDENT + 32'd7, '0));
    send_op(make_op(OP_REMOVE, '0, FIRST_IDENT, '0));
  endtask

  // Mostly live ids and a clock that moves on by about the interval
  function automatic req_t random_op();
    req_t op;
    int pick;
    op = make_op(OP_UNUSED, 16'($urandom_range(0, 65535)), $urandom, $urandom);
    pick = $urandom_range(0, 99);
    if (pick < 36) begin
      op.opcode = OP_INSERT;
    end else if (pick < 66) begin
      op.opcode = OP_REMOVE;
      if (row_count > 0 && $urandom_range(0, 4) != 0)
        op.lookup_id = row_ident[$urandom_range(0, row_count - 1)];
    end else if (pick < 96) begin
      op.opcode = OP_TICK;
      if ($urandom_range(0, 9) == 0)
        tick_clock = $urandom;
      else
        tick_clock = tick_clock + 32'($urandom_range(0, 2 * int'(row_interval) + 2));
      op.now_time = tick_clock;
    end
    return op;
  endfunction

  task automatic test_random_traffic(input logic [15:0] interval, input bit with_idling,
                                     input int count);
    wait_idle();
    write_interval(interval);
    for (int k = 0; k < count; k++) begin
      // occasional stretches with no idling on either side
      if (k % 40 == 0) idling_on = with_idling && ($urandom_range(0, 3) != 0);
      send_op(random_op());
    end
    idling_on = 1'b1;
  endtask

  // Receiver holds off while requests keep coming, so the block backs up
  task automatic test_output_backpressure();
    wait_idle();
    idling_on = 1'b0;
    hold_off_cycles = 400;
    for (int k = 0; k < 30; k++) send_op(random_op());
    idling_on = 1'b1;
  endtask

  initial begin : run
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_fill_and_overflow();
    test_scan_ages();
    test_remove_order();
    test_random_traffic(16'd0, 1'b1, 80);
    test_random_traffic(16'hFFFF, 1'b1, 80);
    test_random_traffic(16'($urandom_range(2, 65534)), 1'b0, 80);
    test_random_traffic(RESET_INTERVAL, 1'b1, 80);
    test_random_traffic(16'($urandom_range(1, 8)), 1'b1, 100);
    test_output_backpressure();
    wait_idle();
    if (mismatch_count == 0 && due_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/rrt_pkg.sv
src/retransmit_request_table.sv
dv/retransmit_request_table_test.sv
